>>> rtl/cbtmx_pkg.sv
package cbtmx_pkg;

  localparam int KEY_W  = 31;
  localparam int MODE_W = 2;
  localparam int STAT_W = 2;

  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_QUERY  = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_POOL_FULL = 2'd1;
  localparam logic [STAT_W-1:0] ST_ABSENT    = 2'd2;
  localparam logic [STAT_W-1:0] ST_CNT_FULL  = 2'd3;

  // Kind of walk the datapath performs on each step.
  typedef enum logic [2:0] {
    OP_QUERY,
    OP_INS_CHK,
    OP_INS_WR,
    OP_REM_CHK,
    OP_REM_WR
  } op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_QUERY,
    S_INS_CHK,
    S_INS_DEC,
    S_INS_WR,
    S_REM_CHK,
    S_REM_DEC,
    S_REM_WR,
    S_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic load_query;
    logic step;
    logic restart;
    op_t  op;
    logic latch_status;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic last;
    logic fail;
    logic out_busy;
  } sts_t;

endpackage

>>> rtl/counted_binary_trie_max_xor_top.sv
// A query walks the trie once from the root, then issues its result; an insert or a
// remove walks it twice (check, then update), and a failed check skips the update walk
// and ends early. Items are taken one at a time, the next only after the result is
// issued; each trie level costs one read of the node memory per walk. A stalled result
// holds off the next item. Reset clears the root node and sets the free-node pointer
// to 1; the node memory needs no clearing pass, as a freshly allocated node reads as
// empty until it is written.
module counted_binary_trie_max_xor_top #(
  parameter int KEY_BITS   = 31,
  parameter int NODE_COUNT = 4096,
  parameter int COUNT_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [30:0] key
  input  logic [1:0]  in_tuser,   // [1:0] mode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [30:0] best_xor
  output logic [2:0]  out_tuser   // [0] found, [2:1] status
);
  import cbtmx_pkg::*;

  cmd_t              cmd;
  sts_t              sts;
  logic [KEY_W-1:0]  best;
  logic              found;
  logic [STAT_W-1:0] status;

  cbtmx_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_mode   (in_tuser),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  cbtmx_dp #(
    .KEY_BITS   (KEY_BITS),
    .NODE_COUNT (NODE_COUNT),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .in_key     (in_tdata[KEY_W-1:0]),
    .out_tready (out_tready),
    .sts        (sts),
    .out_valid  (out_tvalid),
    .out_best   (best),
    .out_found  (found),
    .out_status (status)
  );

  assign out_tdata = {1'b0, best};
  assign out_tuser = {status, found};

  // An accepted item keeps the block busy: input is not taken again straight after it.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted again straight after an item");

  // A successful query never carries an error status.
  a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tuser[2:1] == ST_OK)
    else $error("found result with nonzero status");

  // Without a live match the xor field is zero.
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata == '0)
    else $error("nonzero xor without a match");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("block not idle after reset");

endmodule

>>> rtl/cbtmx_dp.sv
module cbtmx_dp #(
  parameter int KEY_BITS   = 31,
  parameter int NODE_COUNT = 4096,
  parameter int COUNT_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  cbtmx_pkg::cmd_t                 cmd,
  input  logic [cbtmx_pkg::KEY_W-1:0]     in_key,
  input  logic                            out_tready,
  output cbtmx_pkg::sts_t                 sts,
  output logic                            out_valid,
  output logic [cbtmx_pkg::KEY_W-1:0]     out_best,
  output logic                            out_found,
  output logic [cbtmx_pkg::STAT_W-1:0]    out_status
);
  import cbtmx_pkg::*;

  localparam int AW    = $clog2(NODE_COUNT);
  localparam int NFW   = $clog2(NODE_COUNT + 1);
  localparam int SW    = $clog2(NODE_COUNT + KEY_BITS + 1);
  localparam int LVL_W = (KEY_BITS > 1) ? $clog2(KEY_BITS) : 1;
  localparam int MW    = $clog2(KEY_BITS + 1);
  localparam logic [LVL_W-1:0]      LVL_TOP = LVL_W'(KEY_BITS - 1);
  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

  // Each node keeps the links to its two children and the live counts of
  // those children, so one read per level is enough for every decision.
  typedef struct packed {
    logic [1:0][COUNT_BITS-1:0] cnt;
    logic [1:0][AW-1:0]         link;
  } node_t;

  node_t mem [NODE_COUNT];

  node_t             root_r, rdata_r, cur, upd;
  logic [LVL_W-1:0]  lvl_r;
  logic [AW-1:0]     cur_addr_r, nxt_addr, alloc_addr;
  logic [KEY_BITS-1:0] key_r, acc_r, acc_nxt;
  logic [NFW-1:0]    next_free_r, next_free_nxt;
  logic [MW-1:0]     missing_r, missing_nxt;
  logic              halt_r, halt_nxt, fresh_r, fresh_nxt;
  logic              cntf_r, cntf_nxt, absent_r, absent_nxt, found_r, found_nxt;
  logic [STAT_W-1:0] stat_r, stat_calc;
  logic              b, bo, wr_en, pool_full;
  logic [63:0]       key_wide, acc_wide;
  logic              out_valid_r, out_found_r;
  logic [KEY_W-1:0]  out_best_r;
  logic [STAT_W-1:0] out_stat_r;

  assign key_wide   = 64'(in_key);
  assign acc_wide   = 64'(acc_r);
  assign alloc_addr = next_free_r[AW-1:0];

  // A freshly allocated node has never been written, so it reads as empty.
  assign cur = (lvl_r == LVL_TOP) ? root_r : (fresh_r ? '0 : rdata_r);
  assign b   = key_r[lvl_r];
  assign bo  = ~b;

  assign pool_full = (SW'(next_free_r) + SW'(missing_r)) > SW'(NODE_COUNT);

  always_comb begin
    if (pool_full) begin
      stat_calc = ST_POOL_FULL;
    end else if (cntf_r) begin
      stat_calc = ST_CNT_FULL;
    end else if (absent_r) begin
      stat_calc = ST_ABSENT;
    end else begin
      stat_calc = ST_OK;
    end
  end

  always_comb begin
    upd           = cur;
    nxt_addr      = cur.link[b];
    wr_en         = 1'b0;
    acc_nxt       = acc_r;
    halt_nxt      = halt_r;
    fresh_nxt     = 1'b0;
    missing_nxt   = missing_r;
    cntf_nxt      = cntf_r;
    absent_nxt    = absent_r;
    found_nxt     = found_r;
    next_free_nxt = next_free_r;
    if (cmd.step && !halt_r) begin
      case (cmd.op)
        OP_QUERY: begin
          if (cur.link[bo] != '0 && cur.cnt[bo] != '0) begin
            acc_nxt[lvl_r] = 1'b1;
            nxt_addr       = cur.link[bo];
          end else if (cur.link[b] == '0 || cur.cnt[b] == '0) begin
            halt_nxt  = 1'b1;
            found_nxt = 1'b0;
          end
        end
        OP_INS_CHK: begin
          if (cur.link[b] == '0) begin
            // This level and every one below it needs a new node.
            missing_nxt = MW'(lvl_r) + MW'(1);
            halt_nxt    = 1'b1;
          end else if (cur.cnt[b] == CNT_MAX) begin
            cntf_nxt = 1'b1;
          end
        end
        OP_INS_WR: begin
          if (cur.link[b] == '0) begin
            upd.link[b]   = alloc_addr;
            nxt_addr      = alloc_addr;
            next_free_nxt = next_free_r + NFW'(1);
            fresh_nxt     = 1'b1;
          end
          upd.cnt[b] = cur.cnt[b] + COUNT_BITS'(1);
          wr_en      = 1'b1;
        end
        OP_REM_CHK: begin
          if (cur.link[b] == '0 || cur.cnt[b] == '0) begin
            absent_nxt = 1'b1;
            halt_nxt   = 1'b1;
          end
        end
        OP_REM_WR: begin
          upd.cnt[b] = cur.cnt[b] - COUNT_BITS'(1);
          wr_en      = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step) begin
      rdata_r <= mem[nxt_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && lvl_r != LVL_TOP) begin
      mem[cur_addr_r] <= upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      root_r      <= '0;
      next_free_r <= NFW'(1);
      lvl_r       <= LVL_TOP;
      halt_r      <= 1'b0;
      fresh_r     <= 1'b0;
      missing_r   <= '0;
      cntf_r      <= 1'b0;
      absent_r    <= 1'b0;
      found_r     <= 1'b0;
      stat_r      <= ST_OK;
      out_valid_r <= 1'b0;
    end else begin
      if (wr_en && lvl_r == LVL_TOP) begin
        root_r <= upd;
      end
      next_free_r <= next_free_nxt;
      if (cmd.load) begin
        missing_r <= '0;
        cntf_r    <= 1'b0;
        absent_r  <= 1'b0;
        found_r   <= cmd.load_query;
        stat_r    <= ST_OK;
      end else begin
        missing_r <= missing_nxt;
        cntf_r    <= cntf_nxt;
        absent_r  <= absent_nxt;
        found_r   <= found_nxt;
        if (cmd.latch_status) begin
          stat_r <= stat_calc;
        end
      end
      if (cmd.load || cmd.restart) begin
        lvl_r   <= LVL_TOP;
        halt_r  <= 1'b0;
        fresh_r <= 1'b0;
      end else if (cmd.step) begin
        lvl_r   <= lvl_r - LVL_W'(1);
        halt_r  <= halt_nxt;
        fresh_r <= fresh_nxt;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_r <= key_wide[KEY_BITS-1:0];
      acc_r <= '0;
    end else begin
      acc_r <= acc_nxt;
    end
    if (cmd.step) begin
      cur_addr_r <= nxt_addr;
    end
    if (cmd.emit) begin
      out_best_r  <= found_r ? acc_wide[KEY_W-1:0] : '0;
      out_found_r <= found_r;
      out_stat_r  <= stat_r;
    end
  end

  assign sts.last     = (lvl_r == '0);
  assign sts.fail     = (stat_calc != ST_OK);
  assign sts.out_busy = out_valid_r && !out_tready;

  assign out_valid  = out_valid_r;
  assign out_best   = out_best_r;
  assign out_found  = out_found_r;
  assign out_status = out_stat_r;

endmodule

>>> rtl/cbtmx_ctrl.sv
module cbtmx_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  input  logic [cbtmx_pkg::MODE_W-1:0]  in_mode,
  output logic                          in_tready,
  input  cbtmx_pkg::sts_t               sts,
  output cbtmx_pkg::cmd_t               cmd
);
  import cbtmx_pkg::*;

  state_t state_r, state_nxt;
  logic   accept;

  assign accept = in_tvalid && (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_mode)
            MODE_INSERT: state_nxt = S_INS_CHK;
            MODE_REMOVE: state_nxt = S_REM_CHK;
            MODE_QUERY:  state_nxt = S_QUERY;
            default:     state_nxt = S_DONE;
          endcase
        end
      end
      S_QUERY:   if (sts.last) state_nxt = S_DONE;
      S_INS_CHK: if (sts.last) state_nxt = S_INS_DEC;
      S_INS_DEC: state_nxt = sts.fail ? S_DONE : S_INS_WR;
      S_INS_WR:  if (sts.last) state_nxt = S_DONE;
      S_REM_CHK: if (sts.last) state_nxt = S_REM_DEC;
      S_REM_DEC: state_nxt = sts.fail ? S_DONE : S_REM_WR;
      S_REM_WR:  if (sts.last) state_nxt = S_DONE;
      S_DONE:    if (!sts.out_busy) state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd              = '0;
    cmd.op           = OP_QUERY;
    cmd.load         = accept;
    cmd.load_query   = (in_mode == MODE_QUERY);
    case (state_r)
      S_QUERY: begin
        cmd.step = 1'b1;
        cmd.op   = OP_QUERY;
      end
      S_INS_CHK: begin
        cmd.step = 1'b1;
        cmd.op   = OP_INS_CHK;
      end
      S_INS_WR: begin
        cmd.step = 1'b1;
        cmd.op   = OP_INS_WR;
      end
      S_REM_CHK: begin
        cmd.step = 1'b1;
        cmd.op   = OP_REM_CHK;
      end
      S_REM_WR: begin
        cmd.step = 1'b1;
        cmd.op   = OP_REM_WR;
      end
      S_INS_DEC, S_REM_DEC: cmd.latch_status = 1'b1;
      S_DONE:    cmd.emit = !sts.out_busy;
      default: begin
      end
    endcase
    cmd.restart = cmd.step && sts.last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_tready = (state_r == S_IDLE);

endmodule
